### src/impc_pkg.sv
// ----------------------------------------------------------------------------
// impc_pkg
// Shared types and constants of the indexed max-priority collection.
// ----------------------------------------------------------------------------
package impc_pkg;

  localparam int PRIO_W = 16;
  localparam int PAY_W  = 32;
  localparam int ID_W   = 8;
  localparam int META_W = PRIO_W + 1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_PROMOTE = 3'd1,
    CMD_POP     = 3'd2,
    CMD_GET     = 3'd3,
    CMD_VALID   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]       command;
    logic [ID_W-1:0]  item_id;
    logic [PAY_W-1:0] payload_in;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   result_id;
    logic [PRIO_W-1:0] result_priority;
    logic [PAY_W-1:0]  payload_out;
    logic              alive_flag;
    logic [1:0]        status_code;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic lookup;
    logic execute;
    logic scan_run;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic slot_free;
    logic rescan_needed;
    logic scan_done;
  } dp_status_t;

endpackage

### src/impc_ram.sv
// ----------------------------------------------------------------------------
// impc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module impc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/impc_ctrl.sv
// ----------------------------------------------------------------------------
// impc_ctrl
// Sequencer: accept, table lookup, execute, and the rescan after a pop.
// ----------------------------------------------------------------------------
module impc_ctrl import impc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (status_i.slot_free) begin
          state_d = status_i.rescan_needed ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o     = 1'b0;
        ctrl_o.capture = in_valid_i;
      end
      S_LOOKUP: begin
        ctrl_o.lookup = 1'b1;
      end
      S_EXEC: begin
        ctrl_o.execute = status_i.slot_free;
      end
      S_SCAN: begin
        ctrl_o.scan_run = 1'b1;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

### src/impc_datapath.sv
// ----------------------------------------------------------------------------
// impc_datapath
// Entry storage, counters, best-entry tracking, rescan unit and result register.
// ----------------------------------------------------------------------------
module impc_datapath import impc_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  ctrl_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o
);

  localparam int IDW  = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > ID_W) ? CNTW : ID_W;

  cmd_e              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [PAY_W-1:0]  pay_q;
  logic [CNTW-1:0]   next_id_q;
  logic [CNTW-1:0]   cnt_q;
  logic [PRIO_W-1:0] best_prio_q;
  logic [IDW-1:0]    best_id_q;
  logic [CNTW-1:0]   scan_cnt_q;
  logic              scan_vld_q;
  logic [IDW-1:0]    scan_idx_q;
  logic              out_valid_q;
  out_item_t         out_item_q;

  logic              meta_we;
  logic [IDW-1:0]    meta_waddr;
  logic [META_W-1:0] meta_wdata;
  logic              meta_re;
  logic [IDW-1:0]    meta_raddr;
  logic [META_W-1:0] meta_rdata;
  logic              pay_we;
  logic [PAY_W-1:0]  pay_rdata;

  logic [IDW-1:0]    id_idx;
  logic [IDW-1:0]    nid_idx;
  logic              rd_alive;
  logic [PRIO_W-1:0] rd_prio;
  logic              id_alive;
  logic              full;
  logic              empty;
  logic [PRIO_W-1:0] prom_prio;
  logic              prom_beats;
  logic              scan_issue;
  logic              scan_beats;
  logic              slot_free;
  out_item_t         res;

  assign id_idx   = IDW'(id_q);
  assign nid_idx  = IDW'(next_id_q);
  assign rd_alive = meta_rdata[META_W-1];
  assign rd_prio  = meta_rdata[PRIO_W-1:0];

  // Ids at or past the fresh-id counter were never written; their entries are masked.
  assign id_alive = (CMPW'(id_q) < CMPW'(next_id_q)) && rd_alive;
  assign full     = (next_id_q == CNTW'(CAPACITY));
  assign empty    = (cnt_q == '0);

  assign prom_prio  = (rd_prio == '1) ? rd_prio : rd_prio + PRIO_W'(1);
  assign prom_beats = (prom_prio > best_prio_q) ||
                      ((prom_prio == best_prio_q) && (id_idx > best_id_q));

  assign scan_issue = ctrl_i.scan_run && (scan_cnt_q < next_id_q);
  assign scan_beats = rd_alive && ((rd_prio > best_prio_q) ||
                      ((rd_prio == best_prio_q) && (scan_idx_q >= best_id_q)));

  assign slot_free = !out_valid_q || !out_stall_i;

  assign status_o.slot_free     = slot_free;
  assign status_o.rescan_needed = (cmd_q == CMD_POP) && !empty;
  assign status_o.scan_done     = (scan_cnt_q == next_id_q) && !scan_vld_q;

  assign meta_re    = ctrl_i.lookup || scan_issue;
  assign meta_raddr = ctrl_i.scan_run ? IDW'(scan_cnt_q) :
                      ((cmd_q == CMD_POP) || (cmd_q == CMD_GET)) ? best_id_q : id_idx;

  always_comb begin
    res        = '0;
    meta_we    = 1'b0;
    meta_waddr = id_idx;
    meta_wdata = '0;
    pay_we     = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        if (full) begin
          res.status_code = ST_FULL;
        end else begin
          res.result_id = ID_W'(next_id_q);
          meta_we       = ctrl_i.execute;
          meta_waddr    = nid_idx;
          meta_wdata    = {1'b1, {PRIO_W{1'b0}}};
          pay_we        = ctrl_i.execute;
        end
      end
      CMD_PROMOTE: begin
        res.result_id = id_q;
        if (!id_alive) begin
          res.status_code = ST_BAD_ID;
        end else begin
          res.result_priority = prom_prio;
          meta_we             = ctrl_i.execute;
          meta_waddr          = id_idx;
          meta_wdata          = {1'b1, prom_prio};
        end
      end
      CMD_POP, CMD_GET: begin
        if (empty) begin
          res.status_code = ST_EMPTY;
        end else begin
          res.result_id       = ID_W'(best_id_q);
          res.result_priority = best_prio_q;
          res.payload_out     = pay_rdata;
          if (cmd_q == CMD_POP) begin
            meta_we    = ctrl_i.execute;
            meta_waddr = best_id_q;
            meta_wdata = {1'b0, best_prio_q};
          end
        end
      end
      CMD_VALID: begin
        res.result_id  = id_q;
        res.alive_flag = id_alive;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  impc_ram #(
    .WIDTH (META_W),
    .DEPTH (CAPACITY)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (meta_re),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  impc_ram #(
    .WIDTH (PAY_W),
    .DEPTH (CAPACITY)
  ) u_pay_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (nid_idx),
    .wdata_i (pay_q),
    .re_i    (ctrl_i.lookup),
    .raddr_i (best_id_q),
    .rdata_o (pay_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_e'(in_item_i.command);
      id_q  <= in_item_i.item_id;
      pay_q <= in_item_i.payload_in;
    end
    if (scan_issue) begin
      scan_idx_q <= IDW'(scan_cnt_q);
    end
    if (ctrl_i.execute) begin
      out_item_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q   <= '0;
      cnt_q       <= '0;
      best_prio_q <= '0;
      best_id_q   <= '0;
      scan_cnt_q  <= '0;
      scan_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.execute) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (ctrl_i.execute) begin
        case (cmd_q)
          CMD_ADD: begin
            if (!full) begin
              next_id_q <= next_id_q + CNTW'(1);
              cnt_q     <= cnt_q + CNTW'(1);
              if (empty || ((best_prio_q == '0) && (nid_idx > best_id_q))) begin
                best_prio_q <= '0;
                best_id_q   <= nid_idx;
              end
            end
          end
          CMD_PROMOTE: begin
            if (id_alive && prom_beats) begin
              best_prio_q <= prom_prio;
              best_id_q   <= id_idx;
            end
          end
          CMD_POP: begin
            if (!empty) begin
              cnt_q       <= cnt_q - CNTW'(1);
              best_prio_q <= '0;
              best_id_q   <= '0;
              scan_cnt_q  <= '0;
            end
          end
          default: begin
            cnt_q <= cnt_q;
          end
        endcase
      end

      // Rescan: one entry read per cycle, compared in the cycle after its read.
      if (scan_issue) begin
        scan_cnt_q <= scan_cnt_q + CNTW'(1);
      end
      scan_vld_q <= scan_issue;
      if (scan_vld_q && scan_beats) begin
        best_prio_q <= rd_prio;
        best_id_q   <= scan_idx_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### src/indexed_max_priority_collection.sv
// ----------------------------------------------------------------------------
// indexed_max_priority_collection
// Indexed max-priority table with increase-key, controller plus datapath.
// ----------------------------------------------------------------------------
// Flow: an item that transfers passes through lookup, then through execute
// into the result register; execute waits until that register is free.
// A new item is taken only after the last one, and any rescan, is done. A
// pop that removes an entry also rescans the table, one meta RAM read per
// cycle over every id handed out so far, up to CAPACITY ids.
// Reset clears all control state at once; the RAMs need no clearing pass.
module indexed_max_priority_collection import impc_pkg::*; #(
  parameter int CAPACITY = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  // The controller steps each item through lookup and execute. A result is
  // loaded into the output register only when that register is free or is
  // being drained in the same cycle, so no result is ever overwritten.
  ctrl_cmd_t  ctrl;
  dp_status_t status;

  impc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // The datapath keeps priorities and alive bits in one RAM and payloads in
  // another. Entries at or beyond the fresh-id counter are never trusted, so
  // the counter stands in for per-entry reset state. The best entry is
  // tracked incrementally on add and promote, and rebuilt by a full sweep
  // after a pop while the output side is free to drain the pop's result.
  impc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
